/* hw/rtl/ist_pkg.sv */
// Shared types and constants for the interval set table.
package ist_pkg;

	localparam int unsigned MAX_RANGES_DEF = 16;
	localparam int unsigned VALUE_BITS_DEF = 32;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_ERASE  = 2'd1,
		ACT_QUERY  = 2'd2,
		ACT_NOP    = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_MOVE_R,
		ST_MOVE_L,
		ST_WRITE,
		ST_FIN
	} state_t;

	typedef struct packed {
		action_t     action;
		logic [31:0] range_start;
		logic [31:0] range_end;
	} in_word_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] found_start;
		logic [31:0] found_end;
		logic        table_full;
		logic [4:0]  range_count;
	} out_word_t;

endpackage

/* hw/rtl/interval_set_table_core.sv */
// Interval set table: sorted disjoint ranges with insert/merge, erase/split and point query.
// Each word runs scan, decide and finish; a table update adds a right shift or left compact
// and/or a write of the new ranges before finish. A no-op or an empty insert/erase range goes
// from scan to finish; an output stall holds finish. in_ready only when idle, so a new word
// waits for the last. Scan and shift/compact share one read and one write port.
// Reset clears the range count and control state; table entries are undefined until written.
module interval_set_table_core #(
	parameter int unsigned MAX_RANGES = ist_pkg::MAX_RANGES_DEF,
	parameter int unsigned VALUE_BITS = ist_pkg::VALUE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ist_pkg::in_word_t    in_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ist_pkg::out_word_t   out_word
);

	localparam int unsigned IW = $clog2(MAX_RANGES);
	localparam int unsigned CW = $clog2(MAX_RANGES + 1);

	logic [VALUE_BITS-1:0] starts_mem [MAX_RANGES];
	logic [VALUE_BITS-1:0] ends_mem   [MAX_RANGES];

	ist_pkg::state_t  state_q, state_d;
	ist_pkg::action_t op_q;
	logic [VALUE_BITS-1:0] s_q, e_q, si_q, ei_q, ej1_q;
	logic [VALUE_BITS-1:0] w0s_q, w0e_q, w1s_q, w1e_q;
	logic [CW-1:0] cnt_q, k_q, i_q, j_q, lo_q, hi_q, sh_q;
	logic [CW:0]   newcnt_q;
	logic [1:0]    n_q;
	logic          wk_q, ifnd_q, jfnd_q;
	logic          hit_q, full_q;
	logic          out_valid_q;
	ist_pkg::out_word_t out_q;

	logic [IW-1:0] rd_idx, wr_idx;
	logic [VALUE_BITS-1:0] rs, re, wr_s, wr_e;
	logic          wr_en;
	logic          icond, jfail, scan_end;

	// decide terms
	logic          d_splice, d_full;
	logic [CW-1:0] d_hi;
	logic [1:0]    d_n;
	logic [VALUE_BITS-1:0] d_w0s, d_w0e, d_w1s, d_w1e;
	logic [CW:0]   d_newcnt;
	logic [CW-1:0] d_span;
	logic          cut_front, cut_back;

	assign rs = starts_mem[rd_idx];
	assign re = ends_mem[rd_idx];

	assign icond = (op_q == ist_pkg::ACT_INSERT) ? (re >= s_q) : (re > s_q);
	assign jfail = (op_q == ist_pkg::ACT_INSERT) ? (rs > e_q) : (rs >= e_q);
	assign scan_end = (k_q == cnt_q) || (ifnd_q && jfnd_q);

	always_comb begin
		d_splice  = 1'b0;
		d_hi      = i_q;
		d_n       = 2'd0;
		d_w0s     = s_q;
		d_w0e     = e_q;
		d_w1s     = e_q;
		d_w1e     = ej1_q;
		cut_front = (s_q <= si_q);
		cut_back  = (ei_q <= e_q);
		unique case (op_q)
			ist_pkg::ACT_INSERT: begin
				if (i_q == j_q) begin
					d_splice = 1'b1;
					d_n      = 2'd1;
				end else if (!(si_q <= s_q && e_q <= ei_q)) begin
					d_splice = 1'b1;
					d_hi     = j_q;
					d_n      = 2'd1;
					d_w0s    = (si_q < s_q) ? si_q : s_q;
					d_w0e    = (ej1_q > e_q) ? ej1_q : e_q;
				end
			end
			ist_pkg::ACT_ERASE: begin
				if (i_q != j_q) begin
					d_splice = 1'b1;
					d_hi     = j_q;
					if (j_q == i_q + CW'(1) && cut_front != cut_back) begin
						d_n   = 2'd1;
						d_w0s = cut_front ? e_q : si_q;
						d_w0e = cut_front ? ei_q : s_q;
					end else if (si_q < s_q) begin
						d_w0s = si_q;
						d_w0e = s_q;
						d_n   = (e_q < ej1_q) ? 2'd2 : 2'd1;
					end else begin
						d_w0s = e_q;
						d_w0e = ej1_q;
						d_n   = (e_q < ej1_q) ? 2'd1 : 2'd0;
					end
				end
			end
			default: begin
				d_splice = 1'b0;
			end
		endcase
		d_span   = d_hi - i_q;
		d_newcnt = {1'b0, cnt_q} + (CW+1)'(d_n) - {1'b0, d_span};
		d_full   = d_splice && (d_newcnt > (CW+1)'(MAX_RANGES));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ist_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = ist_pkg::ST_SCAN;
				end
			end
			ist_pkg::ST_SCAN: begin
				if (op_q == ist_pkg::ACT_NOP ||
				    (op_q != ist_pkg::ACT_QUERY && s_q >= e_q)) begin
					state_d = ist_pkg::ST_FIN;
				end else if (scan_end) begin
					state_d = ist_pkg::ST_DECIDE;
				end
			end
			ist_pkg::ST_DECIDE: begin
				if (!d_splice || d_full) begin
					state_d = ist_pkg::ST_FIN;
				end else if (CW'(d_n) > d_span) begin
					state_d = ist_pkg::ST_MOVE_R;
				end else if (CW'(d_n) < d_span) begin
					state_d = ist_pkg::ST_MOVE_L;
				end else begin
					state_d = ist_pkg::ST_WRITE;
				end
			end
			ist_pkg::ST_MOVE_R: begin
				if (k_q == hi_q) begin
					state_d = (n_q == 2'd0) ? ist_pkg::ST_FIN : ist_pkg::ST_WRITE;
				end
			end
			ist_pkg::ST_MOVE_L: begin
				if (k_q == cnt_q) begin
					state_d = (n_q == 2'd0) ? ist_pkg::ST_FIN : ist_pkg::ST_WRITE;
				end
			end
			ist_pkg::ST_WRITE: begin
				if ({1'b0, wk_q} == n_q - 2'd1) begin
					state_d = ist_pkg::ST_FIN;
				end
			end
			ist_pkg::ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					state_d = ist_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ist_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		rd_idx = k_q[IW-1:0];
		wr_en  = 1'b0;
		wr_idx = k_q[IW-1:0];
		wr_s   = rs;
		wr_e   = re;
		unique case (state_q)
			ist_pkg::ST_MOVE_R: begin
				rd_idx = IW'(k_q - CW'(1));
				wr_idx = k_q[IW-1:0];
				wr_en  = (k_q != hi_q);
			end
			ist_pkg::ST_MOVE_L: begin
				wr_idx = IW'(k_q - sh_q);
				wr_en  = (k_q != cnt_q);
			end
			ist_pkg::ST_WRITE: begin
				wr_idx = IW'(lo_q + CW'(wk_q));
				wr_en  = 1'b1;
				wr_s   = wk_q ? w1s_q : w0s_q;
				wr_e   = wk_q ? w1e_q : w0e_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	assign in_ready  = (state_q == ist_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			starts_mem[wr_idx] <= wr_s;
			ends_mem[wr_idx]   <= wr_e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ist_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ist_pkg::ST_FIN && state_d == ist_pkg::ST_IDLE) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if ((state_q == ist_pkg::ST_MOVE_R || state_q == ist_pkg::ST_MOVE_L ||
			     state_q == ist_pkg::ST_WRITE) && state_d == ist_pkg::ST_FIN) begin
				cnt_q <= newcnt_q[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ist_pkg::ST_IDLE: begin
				op_q   <= in_word.action;
				s_q    <= VALUE_BITS'(in_word.range_start);
				e_q    <= VALUE_BITS'(in_word.range_end);
				k_q    <= '0;
				i_q    <= cnt_q;
				j_q    <= cnt_q;
				ifnd_q <= 1'b0;
				jfnd_q <= 1'b0;
				hit_q  <= 1'b0;
				full_q <= 1'b0;
				wk_q   <= 1'b0;
			end
			ist_pkg::ST_SCAN: begin
				if (!scan_end) begin
					k_q <= k_q + CW'(1);
					if (!ifnd_q && icond) begin
						ifnd_q <= 1'b1;
						i_q    <= k_q;
						si_q   <= rs;
						ei_q   <= re;
					end
					if (!jfnd_q) begin
						if (jfail) begin
							jfnd_q <= 1'b1;
							j_q    <= k_q;
						end else begin
							ej1_q <= re;
						end
					end
				end
			end
			ist_pkg::ST_DECIDE: begin
				hit_q    <= (op_q == ist_pkg::ACT_QUERY) && ifnd_q && (si_q <= s_q);
				full_q   <= d_full;
				lo_q     <= i_q;
				hi_q     <= d_hi;
				n_q      <= d_n;
				w0s_q    <= d_w0s;
				w0e_q    <= d_w0e;
				w1s_q    <= d_w1s;
				w1e_q    <= d_w1e;
				newcnt_q <= d_newcnt;
				sh_q     <= d_span - CW'(d_n);
				k_q      <= (CW'(d_n) > d_span) ? cnt_q : d_hi;
			end
			ist_pkg::ST_MOVE_R: begin
				if (k_q != hi_q) begin
					k_q <= k_q - CW'(1);
				end
			end
			ist_pkg::ST_MOVE_L: begin
				if (k_q != cnt_q) begin
					k_q <= k_q + CW'(1);
				end
			end
			ist_pkg::ST_WRITE: begin
				wk_q <= 1'b1;
			end
			ist_pkg::ST_FIN: begin
				if (state_d == ist_pkg::ST_IDLE) begin
					out_q.hit         <= hit_q;
					out_q.found_start <= hit_q ? 32'(si_q) : 32'd0;
					out_q.found_end   <= hit_q ? 32'(ei_q) : 32'd0;
					out_q.table_full  <= full_q;
					out_q.range_count <= 5'(cnt_q);
				end
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

endmodule

/* tb/sv/ist_checker.sv */
// Checker for the interval set table: watches both channels, predicts results, compares.
module ist_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  ist_pkg::in_word_t  in_word,
	input  logic               out_valid,
	input  logic               out_ready,
	input  ist_pkg::out_word_t out_word,
	output int unsigned        fail_count,
	output int unsigned        pending,
	output int unsigned        full_seen,
	output int unsigned        hit_seen
);

	localparam int unsigned CAP = ist_pkg::MAX_RANGES_DEF;

	logic [31:0] tbl_lo [CAP];
	logic [31:0] tbl_hi [CAP];
	int unsigned tbl_n;
	ist_pkg::out_word_t want_q [$];

	task automatic report(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		fail_count++;
	endtask

	// replace entries [lo,hi) with n new ranges
	function automatic void replace_span(input int unsigned lo, input int unsigned hi,
			input int unsigned n, input logic [31:0] ns [2], input logic [31:0] ne [2]);
		logic [31:0] ts [CAP];
		logic [31:0] te [CAP];
		int unsigned c;
		c = 0;
		for (int unsigned k = 0; k < lo; k++) begin
			ts[c] = tbl_lo[k]; te[c] = tbl_hi[k]; c++;
		end
		for (int unsigned k = 0; k < n; k++) begin
			ts[c] = ns[k]; te[c] = ne[k]; c++;
		end
		for (int unsigned k = hi; k < tbl_n; k++) begin
			ts[c] = tbl_lo[k]; te[c] = tbl_hi[k]; c++;
		end
		for (int unsigned k = 0; k < c; k++) begin
			tbl_lo[k] = ts[k]; tbl_hi[k] = te[k];
		end
		tbl_n = c;
	endfunction

	function automatic bit add_range(input logic [31:0] s, input logic [31:0] e);
		int unsigned i, j;
		logic [31:0] ns [2];
		logic [31:0] ne [2];
		if (s >= e) return 0;
		i = 0;
		while (i < tbl_n && tbl_hi[i] < s) i++;
		j = i;
		while (j < tbl_n && tbl_lo[j] <= e) j++;
		if (i == j) begin
			if (tbl_n >= CAP) return 1;
			ns[0] = s; ne[0] = e;
			replace_span(i, i, 1, ns, ne);
			return 0;
		end
		if (tbl_lo[i] <= s && e <= tbl_hi[i]) return 0;
		ns[0] = (tbl_lo[i] < s) ? tbl_lo[i] : s;
		ne[0] = (tbl_hi[j-1] > e) ? tbl_hi[j-1] : e;
		replace_span(i, j, 1, ns, ne);
		return 0;
	endfunction

	function automatic bit cut_range(input logic [31:0] s, input logic [31:0] e);
		int unsigned i, j, n;
		logic [31:0] ns [2];
		logic [31:0] ne [2];
		bit front, back;
		if (s >= e) return 0;
		i = 0;
		n = 0;
		while (i < tbl_n && tbl_hi[i] <= s) i++;
		j = i;
		while (j < tbl_n && tbl_lo[j] < e) j++;
		if (i == j) return 0;
		if (j == i + 1) begin
			front = s <= tbl_lo[i];
			back = tbl_hi[i] <= e;
			if (front != back) begin
				if (front) tbl_lo[i] = e;
				else tbl_hi[i] = s;
				return 0;
			end
		end
		if (tbl_lo[i] < s) begin
			ns[n] = tbl_lo[i]; ne[n] = s; n++;
		end
		if (e < tbl_hi[j-1]) begin
			ns[n] = e; ne[n] = tbl_hi[j-1]; n++;
		end
		if (tbl_n - (j - i) + n > CAP) return 1;
		replace_span(i, j, n, ns, ne);
		return 0;
	endfunction

	function automatic ist_pkg::out_word_t apply_word(input ist_pkg::in_word_t w);
		ist_pkg::out_word_t r;
		int unsigned i;
		r = '0;
		case (w.action)
			ist_pkg::ACT_INSERT: r.table_full = add_range(w.range_start, w.range_end);
			ist_pkg::ACT_ERASE:  r.table_full = cut_range(w.range_start, w.range_end);
			ist_pkg::ACT_QUERY: begin
				i = 0;
				while (i < tbl_n && tbl_hi[i] <= w.range_start) i++;
				if (i < tbl_n && tbl_lo[i] <= w.range_start) begin
					r.hit = 1;
					r.found_start = tbl_lo[i];
					r.found_end = tbl_hi[i];
				end
			end
			default: ;
		endcase
		r.range_count = 5'(tbl_n);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ist_pkg::out_word_t w;
		if (!arst_n) begin
			tbl_n = 0;
			want_q.delete();
			fail_count = 0;
			pending = 0;
			full_seen = 0;
			hit_seen = 0;
		end else begin
			if (in_valid && in_ready) want_q.push_back(apply_word(in_word));
			if (out_valid && out_ready) begin
				if (want_q.size() == 0) begin
					report("result word with none expected");
				end else begin
					w = want_q.pop_front();
					if (out_word.hit !== w.hit)
						report($sformatf("hit %0b want %0b", out_word.hit, w.hit));
					if (out_word.found_start !== w.found_start)
						report($sformatf("found_start %h want %h",
							out_word.found_start, w.found_start));
					if (out_word.found_end !== w.found_end)
						report($sformatf("found_end %h want %h",
							out_word.found_end, w.found_end));
					if (out_word.table_full !== w.table_full)
						report($sformatf("table_full %0b want %0b",
							out_word.table_full, w.table_full));
					if (out_word.range_count !== w.range_count)
						report($sformatf("range_count %0d want %0d",
							out_word.range_count, w.range_count));
					if (w.table_full) full_seen++;
					if (w.hit) hit_seen++;
				end
			end
			pending = want_q.size();
		end
	end
endmodule

/* tb/sv/tb_top.sv */
// Testbench top for the interval set table: stimulus, idling, verdict.
module tb_top;

	localparam int unsigned N_RAND = 1950;
	localparam longint LIMIT = 1000000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	ist_pkg::in_word_t in_word = '0;
	logic out_valid;
	logic out_ready = 0;
	ist_pkg::out_word_t out_word;
	int unsigned fail_count, pending, full_seen, hit_seen;
	longint cycles = 0;
	bit calm = 0;
	int unsigned sent = 0;

	always #5 clk = ~clk;

	interval_set_table_core dut (.*);

	ist_checker chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("** interval_set_table_core: FAILED **");
			$finish;
		end
	end

	// receiver stalls in bursts
	initial begin
		int unsigned n;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 16);
				out_ready <= 0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1;
		end
	end

	task automatic send_word(input ist_pkg::action_t a, input logic [31:0] s,
			input logic [31:0] e);
		int unsigned n;
		if (!calm && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 16);
			in_valid <= 0;
			repeat (n) @(posedge clk);
		end
		in_word <= '{action: a, range_start: s, range_end: e};
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
	endtask

	function automatic logic [31:0] pick_val(input int unsigned span);
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			2: return $urandom_range(0, 3);
			default: return $urandom_range(0, span);
		endcase
	endfunction

	initial begin
		logic [31:0] s, e;
		int unsigned span, k;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed
		send_word(ist_pkg::ACT_QUERY, 32'd5, 32'd0);
		send_word(ist_pkg::ACT_INSERT, 32'd10, 32'd20);
		send_word(ist_pkg::ACT_INSERT, 32'd20, 32'd30);
		send_word(ist_pkg::ACT_INSERT, 32'd5, 32'd10);
		send_word(ist_pkg::ACT_INSERT, 32'd12, 32'd15);
		send_word(ist_pkg::ACT_INSERT, 32'd40, 32'd40);
		send_word(ist_pkg::ACT_QUERY, 32'd29, 32'd0);
		send_word(ist_pkg::ACT_QUERY, 32'd30, 32'd0);
		send_word(ist_pkg::ACT_ERASE, 32'd0, 32'd8);
		send_word(ist_pkg::ACT_ERASE, 32'd25, 32'd40);
		send_word(ist_pkg::ACT_ERASE, 32'd12, 32'd14);
		send_word(ist_pkg::ACT_ERASE, 32'd9, 32'd3);
		send_word(ist_pkg::ACT_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(ist_pkg::ACT_INSERT, 32'h0, 32'hFFFF_FFFF);
		send_word(ist_pkg::ACT_QUERY, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
		send_word(ist_pkg::ACT_ERASE, 32'h0, 32'hFFFF_FFFF);
		for (k = 0; k < 16; k++)
			send_word(ist_pkg::ACT_INSERT, 32'(k * 4), 32'(k * 4 + 2));
		send_word(ist_pkg::ACT_INSERT, 32'd100, 32'd101);
		send_word(ist_pkg::ACT_ERASE, 32'd0, 32'd1);
		send_word(ist_pkg::ACT_QUERY, 32'd60, 32'd0);
		// random: small value span keeps the table busy, wide spans now and then
		for (k = 0; k < N_RAND; k++) begin
			if (k > N_RAND - 150) calm = 1;
			span = (k % 400 < 300) ? 200 : 32'hFFFF_FFFF;
			s = pick_val(span);
			e = ($urandom_range(0, 7) == 0) ? pick_val(span) : s + $urandom_range(1, 12);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: send_word(ist_pkg::ACT_INSERT, s, e);
				4, 5, 6: send_word(ist_pkg::ACT_ERASE, s, e);
				7, 8: send_word(ist_pkg::ACT_QUERY, s, e);
				default: send_word(ist_pkg::action_t'($urandom_range(0, 3)),
					$urandom(), $urandom());
			endcase
		end
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("%0d words sent: inserts, erases, queries and no-ops", sent);
		$display("%0d query hits and %0d capacity refusals checked", hit_seen, full_seen);
		if (fail_count == 0)
			$display("** interval_set_table_core: PASSED **");
		else
			$display("** interval_set_table_core: FAILED **");
		$finish;
	end
endmodule
